/* sv/tarc_pkg.sv */
package tarc_pkg;

    localparam int ACC_FRAC  = 24;
    localparam int NORM_TOP  = 61;
    localparam int HALF_TURN = 180;
    localparam int CW        = 64;   // CORDIC datapath width

    localparam logic [63:0] FULL_Z    = 64'(HALF_TURN) << ACC_FRAC;
    localparam logic [63:0] QUARTER_Z = (64'(HALF_TURN) << ACC_FRAC) >> 1;

    typedef enum logic [0:0] {
        REG_MIN = 1'b0,
        REG_MAX = 1'b1
    } reg_idx_t;

    function automatic logic [31:0] atan_deg(input int i);
        logic [31:0] t;
        begin
            case (i)
                0:  t = 32'd754974720;
                1:  t = 32'd445687602;
                2:  t = 32'd235489088;
                3:  t = 32'd119537938;
                4:  t = 32'd60000934;
                5:  t = 32'd30029717;
                6:  t = 32'd15018523;
                7:  t = 32'd7509720;
                8:  t = 32'd3754917;
                9:  t = 32'd1877466;
                10: t = 32'd938734;
                11: t = 32'd469367;
                12: t = 32'd234684;
                13: t = 32'd117342;
                14: t = 32'd58671;
                15: t = 32'd29335;
                16: t = 32'd14668;
                17: t = 32'd7334;
                18: t = 32'd3667;
                19: t = 32'd1833;
                20: t = 32'd917;
                21: t = 32'd458;
                22: t = 32'd229;
                23: t = 32'd115;
                24: t = 32'd57;
                25: t = 32'd29;
                26: t = 32'd14;
                27: t = 32'd7;
                28: t = 32'd4;
                29: t = 32'd2;
                30: t = 32'd1;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

    // special-case codes carried beside the CORDIC
    typedef struct packed {
        logic dneg;
        logic xz;
        logic yz;
    } corner_flags_t;

endpackage

/* sv/triangle_angle_range_check.sv */
// Pipeline: CORDIC_STEPS + 6 register stages (CORDIC_STEPS capped at 32).
// Throughput: one triangle per cycle unless stalled; three corner lanes run in parallel,
// each a fully pipelined CORDIC with one iteration per stage.
// The whole pipeline advances together and holds when the result is stalled.
// Reset (rst_n low, async): pipeline empty, min_angle = 0, max_angle = 46080.
module triangle_angle_range_check import tarc_pkg::*; #(
    parameter int COORD_BITS      = 32,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] vertex_a_x,
    input  logic signed [COORD_BITS-1:0] vertex_a_y,
    input  logic signed [COORD_BITS-1:0] vertex_b_x,
    input  logic signed [COORD_BITS-1:0] vertex_b_y,
    input  logic signed [COORD_BITS-1:0] vertex_c_x,
    input  logic signed [COORD_BITS-1:0] vertex_c_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [15:0]                  angle_at_a,
    output logic [15:0]                  angle_at_b,
    output logic [15:0]                  angle_at_c,
    output logic                         out_of_range
);
    localparam int NS    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int DEPTH = NS + 6;

    logic [15:0] min_reg, max_reg;
    logic        en;
    logic [DEPTH-1:0] vld_reg;
    logic        wr;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= 16'd0;
            max_reg <= 16'd46080;
        end
        else if (wr && !paddr[1] && !paddr[0])
        begin
            case (idx)
                REG_MIN: min_reg <= pwdata[15:0];
                REG_MAX: max_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN: prdata = {16'd0, min_reg};
            REG_MAX: prdata = {16'd0, max_reg};
            default: prdata = '0;
        endcase
    end

    // advance unless the final result is stalled
    assign en       = !(vld_reg[DEPTH-1] && !out_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    logic [15:0] ang_a, ang_b, ang_c;

    tarc_lane #(.COORD_BITS(COORD_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .CORDIC_STEPS(CORDIC_STEPS)) u_lane_a (
        .clk(clk), .en(en),
        .px(vertex_a_x), .py(vertex_a_y), .qx(vertex_b_x), .qy(vertex_b_y),
        .rx(vertex_c_x), .ry(vertex_c_y), .angle(ang_a));

    tarc_lane #(.COORD_BITS(COORD_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .CORDIC_STEPS(CORDIC_STEPS)) u_lane_b (
        .clk(clk), .en(en),
        .px(vertex_b_x), .py(vertex_b_y), .qx(vertex_a_x), .qy(vertex_a_y),
        .rx(vertex_c_x), .ry(vertex_c_y), .angle(ang_b));

    tarc_lane #(.COORD_BITS(COORD_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                .CORDIC_STEPS(CORDIC_STEPS)) u_lane_c (
        .clk(clk), .en(en),
        .px(vertex_c_x), .py(vertex_c_y), .qx(vertex_a_x), .qy(vertex_a_y),
        .rx(vertex_b_x), .ry(vertex_b_y), .angle(ang_c));

    tarc_merge u_merge (
        .clk(clk), .en(en),
        .ang_a(ang_a), .ang_b(ang_b), .ang_c(ang_c),
        .min_angle(min_reg), .max_angle(max_reg),
        .out_a(angle_at_a), .out_b(angle_at_b), .out_c(angle_at_c),
        .out_flag(out_of_range));

    assign out_valid = vld_reg[DEPTH-1];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_at_a))
        else $error("result changed while stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without a stalled result");

    a_angle_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ANGLE_FRAC_BITS == 8) |-> angle_at_a <= 16'd46080)
        else $error("angle above half turn");
endmodule

/* sv/tarc_lane.sv */
// One corner: exact products, normalize, pipelined CORDIC, round.
module tarc_lane import tarc_pkg::*; #(
    parameter int COORD_BITS      = 32,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] rx,
    input  logic signed [COORD_BITS-1:0] ry,
    output logic [15:0]                  angle
);
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int LW  = $clog2(SW + 1);
    localparam int NS  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int RSH = ACC_FRAC - ANGLE_FRAC_BITS;

    // stage 1: differences
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    // stage 2: products
    logic signed [PW-1:0] p_uxvx_reg, p_uyvy_reg, p_uxvy_reg, p_uyvx_reg;
    // stage 3: magnitudes
    logic [SW-1:0]        mx_reg, my_reg;
    corner_flags_t        f3_reg, f4_reg;
    // stage 4: normalized
    logic [CW-1:0]        nx_reg, ny_reg;

    logic signed [SW-1:0] dot, crs;
    logic [SW-1:0]        orv;
    logic [LW-1:0]        len;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg <= DW'(px) - DW'(qx);
            uy_reg <= DW'(py) - DW'(qy);
            vx_reg <= DW'(px) - DW'(rx);
            vy_reg <= DW'(py) - DW'(ry);
            p_uxvx_reg <= PW'(ux_reg) * PW'(vx_reg);
            p_uyvy_reg <= PW'(uy_reg) * PW'(vy_reg);
            p_uxvy_reg <= PW'(ux_reg) * PW'(vy_reg);
            p_uyvx_reg <= PW'(uy_reg) * PW'(vx_reg);
        end
    end

    always_comb
    begin
        dot = SW'(p_uxvx_reg) + SW'(p_uyvy_reg);
        crs = SW'(p_uxvy_reg) - SW'(p_uyvx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= dot[SW-1] ? SW'(-dot) : SW'(dot);
            my_reg <= crs[SW-1] ? SW'(-crs) : SW'(crs);
            f3_reg.dneg <= dot[SW-1];
            f3_reg.xz   <= (dot == '0);
            f3_reg.yz   <= (crs == '0);
        end
    end

    always_comb
    begin
        orv = mx_reg | my_reg;
        len = '0;
        for (int b = 0; b < SW; b++)
        begin
            if (orv[b])
                len = LW'(b + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (int'(len) > NORM_TOP)
            begin
                nx_reg <= CW'(mx_reg >> (int'(len) - NORM_TOP));
                ny_reg <= CW'(my_reg >> (int'(len) - NORM_TOP));
            end
            else
            begin
                nx_reg <= CW'(mx_reg) << (NORM_TOP - int'(len));
                ny_reg <= CW'(my_reg) << (NORM_TOP - int'(len));
            end
            f4_reg <= f3_reg;
        end
    end

    // CORDIC stages, one iteration each
    logic [CW-1:0] x_reg [NS+1];
    logic [CW-1:0] y_reg [NS+1];
    logic signed [63:0] z_reg [NS+1];
    corner_flags_t fl_reg [NS+1];

    always_comb
    begin
        x_reg[0]  = nx_reg;
        y_reg[0]  = ny_reg;
        z_reg[0]  = '0;
        fl_reg[0] = f4_reg;
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic [CW-1:0] dx, dy;
        assign dx = CW'($signed(y_reg[i]) >>> i);
        assign dy = x_reg[i] >> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + 64'(atan_deg(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - 64'(atan_deg(i));
                end
                fl_reg[i+1] <= fl_reg[i];
            end
        end
    end

    // finish: specials, clamp, mirror, round
    logic signed [63:0] zc, zf;
    logic [63:0]        rnd;
    corner_flags_t      ff;
    logic [15:0]        angle_reg;

    always_comb
    begin
        ff = fl_reg[NS];
        zc = z_reg[NS];
        if (zc < 0)
            zc = '0;
        if (zc > $signed(QUARTER_Z))
            zc = $signed(QUARTER_Z);
        if (ff.xz && ff.yz)
            zf = '0;
        else if (ff.yz)
            zf = ff.dneg ? $signed(FULL_Z) : '0;
        else if (ff.xz)
            zf = $signed(QUARTER_Z);
        else
            zf = ff.dneg ? $signed(FULL_Z) - zc : zc;
        rnd = (64'(zf) + (64'd1 << (RSH - 1))) >> RSH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= (rnd > 64'hFFFF) ? 16'hFFFF : rnd[15:0];
    end

    assign angle = angle_reg;
endmodule

/* sv/tarc_merge.sv */
// Combine lane angles and window test into one result register.
module tarc_merge import tarc_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] ang_a,
    input  logic [15:0] ang_b,
    input  logic [15:0] ang_c,
    input  logic [15:0] min_angle,
    input  logic [15:0] max_angle,
    output logic [15:0] out_a,
    output logic [15:0] out_b,
    output logic [15:0] out_c,
    output logic        out_flag
);
    logic [15:0] a_reg, b_reg, c_reg;
    logic        flag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= ang_a;
            b_reg    <= ang_b;
            c_reg    <= ang_c;
            flag_reg <= (ang_a < min_angle) || (ang_a > max_angle) ||
                        (ang_b < min_angle) || (ang_b > max_angle) ||
                        (ang_c < min_angle) || (ang_c > max_angle);
        end
    end

    assign out_a    = a_reg;
    assign out_b    = b_reg;
    assign out_c    = c_reg;
    assign out_flag = flag_reg;
endmodule

/* tb/sv/tb_triangle_angle_range_check.sv */
`timescale 1ns / 1ps

module tb_triangle_angle_range_check;
    import tarc_pkg::*;

    localparam int STEPS      = 16;
    localparam int LATENCY    = STEPS + 6;
    localparam int WATCH_MAX  = 20000;
    localparam int DEG_FRAC   = 8;
    localparam longint Z_HALF = longint'(180) << 24;
    localparam longint Z_QTR  = longint'(90) << 24;

    typedef struct packed {
        logic [15:0] ang_a;
        logic [15:0] ang_b;
        logic [15:0] ang_c;
        logic        flag;
    } angles_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic signed [31:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
    logic signed [31:0] vertex_c_x, vertex_c_y;
    logic out_valid, out_ready;
    logic [15:0] angle_at_a, angle_at_b, angle_at_c;
    logic out_of_range;

    angles_t angles_due[$];
    logic [15:0] lo_deg, hi_deg;
    int snd_idle, rcv_idle, rcv_hold;
    int n_errors, quiet_cycles;

    longint atan_tbl[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335};

    triangle_angle_range_check u_top (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] corner_deg(input logic signed [127:0] px, py, qx, qy,
                                               rx, ry);
        logic signed [127:0] ux, uy, vx, vy, dot, crs;
        logic [127:0] mx, my, both;
        logic [63:0] x, y, dx, dy, rnd;
        logic dneg;
        longint z;
        int len;
        ux = px - qx;
        uy = py - qy;
        vx = px - rx;
        vy = py - ry;
        dot = ux * vx + uy * vy;
        crs = ux * vy - uy * vx;
        dneg = dot[127];
        mx = dneg ? -dot : dot;
        my = crs[127] ? -crs : crs;
        if (mx == 0 && my == 0)
            z = 0;
        else if (my == 0)
            z = dneg ? Z_HALF : 0;
        else if (mx == 0)
            z = Z_QTR;
        else
        begin
            both = mx | my;
            len = 0;
            for (int i = 127; i >= 0; i--)
            begin
                if (both[i])
                begin
                    len = i + 1;
                    break;
                end
            end
            if (len > 61)
            begin
                mx = mx >> (len - 61);
                my = my >> (len - 61);
                x = mx[63:0];
                y = my[63:0];
            end
            else
            begin
                x = mx[63:0] << (61 - len);
                y = my[63:0] << (61 - len);
            end
            z = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                dx = $signed(y) >>> i;
                dy = x >> i;
                if (!y[63])
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_tbl[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_tbl[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > Z_QTR)
                z = Z_QTR;
            if (dneg)
                z = Z_HALF - z;
        end
        rnd = (64'(z) + (64'd1 << (24 - DEG_FRAC - 1))) >> (24 - DEG_FRAC);
        return (rnd > 64'hFFFF) ? 16'hFFFF : rnd[15:0];
    endfunction

    function automatic angles_t triangle_angles(input logic signed [31:0] ax, ay, bx, by,
                                                cx, cy);
        angles_t r;
        r.ang_a = corner_deg(ax, ay, bx, by, cx, cy);
        r.ang_b = corner_deg(bx, by, ax, ay, cx, cy);
        r.ang_c = corner_deg(cx, cy, ax, ay, bx, by);
        r.flag = (r.ang_a < lo_deg) || (r.ang_a > hi_deg) || (r.ang_b < lo_deg)
              || (r.ang_b > hi_deg) || (r.ang_c < lo_deg) || (r.ang_c > hi_deg);
        return r;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(idx) << 2;
        pwdata <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MIN)
            lo_deg = val;
        else
            hi_deg = val;
    endtask

    task automatic send_triangle(input logic signed [31:0] ax, ay, bx, by, cx, cy);
        int gap;
        logic taken;
        gap = 0;
        while ($urandom_range(99) < snd_idle)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_a_x <= ax;
        vertex_a_y <= ay;
        vertex_b_x <= bx;
        vertex_b_y <= by;
        vertex_c_x <= cx;
        vertex_c_y <= cy;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
                angles_due.insert(angles_due.size(),
                                  triangle_angles(ax, ay, bx, by, cx, cy));
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(2000))) - 1000;
            default: return $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic signed [31:0] c[6];
        int mode, kind;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(2);
            foreach (c[k])
                c[k] = rand_coord(mode);
            kind = $urandom_range(9);
            // steer some triangles onto degenerate, collinear and right corners
            if (kind == 0)
            begin
                c[2] = c[0];
                c[3] = c[1];
            end
            else if (kind == 1)
            begin
                c[4] = c[0] + (c[2] - c[0]) * 2;
                c[5] = c[1] + (c[3] - c[1]) * 2;
            end
            else if (kind == 2)
            begin
                c[4] = c[0] - (c[3] - c[1]);
                c[5] = c[1] + (c[2] - c[0]);
            end
            send_triangle(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] mn, mxv;
        mn = 32'sh8000_0000;
        mxv = 32'sh7FFF_FFFF;
        send_triangle(mn, mn, mxv, mn, mn, mxv);
        send_triangle(mxv, mxv, mn, mxv, mxv, mn);
        send_triangle(mn, mxv, mxv, mn, mn, mn);
        send_triangle(mn, mn, mxv, mxv, mn, mxv);
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(mxv, mn, mxv, mn, mxv, mn);
        send_triangle(0, 0, 0, 0, 32'sh0001_0000, 0);
        send_triangle(0, 0, 32'sh0001_0000, 0, 32'sh0002_0000, 0);
        send_triangle(0, 0, 32'sh0002_0000, 0, 32'sh0001_0000, 0);
        send_triangle(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);
        send_triangle(0, 0, 32'sh0002_0000, 0, 32'sh0001_0000, 32'sh0001_BB68);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, 1000000, 0, -1000000, 1);
        send_triangle(-1, -1, 1, 1, -1, 1);
        send_triangle(0, 0, 10, 0, 5, 1);
        send_triangle(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                      32'sh1234_5678, 32'shEDCB_A987);
        drain();
    endtask

    task automatic test_windows();
        logic [15:0] lo_set[6] = '{0, 0, 46080, 7680, 30720, 0};
        logic [15:0] hi_set[6] = '{0, 46080, 46080, 30720, 7680, 23040};
        for (int s = 0; s < 6; s++)
        begin
            write_reg(REG_MIN, lo_set[s]);
            write_reg(REG_MAX, hi_set[s]);
            send_random(40);
            drain();
        end
        write_reg(REG_MIN, 16'($urandom_range(46080)));
        write_reg(REG_MAX, 16'($urandom_range(46080)));
        send_random(40);
        drain();
        write_reg(REG_MIN, 16'd5120);
        write_reg(REG_MAX, 16'd40960);
    endtask

    task automatic test_idling();
        snd_idle = 12;
        rcv_idle = 71;
        send_random(200);
        snd_idle = 71;
        rcv_idle = 12;
        send_random(200);
        snd_idle = 0;
        rcv_idle = 0;
        send_random(200);
        drain();
    endtask

    task automatic test_backpressure();
        snd_idle = 0;
        rcv_hold = 300;
        send_random(60);
        // pause until everything is back, then resume
        drain();
        rcv_idle = 30;
        send_random(40);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rcv_hold > 0)
        begin
            rcv_hold <= rcv_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(negedge clk)
    begin
        angles_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (angles_due.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result a=%0d b=%0d c=%0d flag=%0b", $time,
                         angle_at_a, angle_at_b, angle_at_c, out_of_range);
            end
            else
            begin
                want = angles_due.pop_front();
                if (angle_at_a !== want.ang_a)
                begin
                    n_errors++;
                    $display("%0t: angle_at_a expected %0d got %0d", $time, want.ang_a,
                             angle_at_a);
                end
                if (angle_at_b !== want.ang_b)
                begin
                    n_errors++;
                    $display("%0t: angle_at_b expected %0d got %0d", $time, want.ang_b,
                             angle_at_b);
                end
                if (angle_at_c !== want.ang_c)
                begin
                    n_errors++;
                    $display("%0t: angle_at_c expected %0d got %0d", $time, want.ang_c,
                             angle_at_c);
                end
                if (out_of_range !== want.flag)
                begin
                    n_errors++;
                    $display("%0t: out_of_range expected %0b got %0b", $time, want.flag,
                             out_of_range);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX)
        begin
            $display("%0t: no progress, giving up", $time);
            $display("** triangle_angle_range_check: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        vertex_a_x = '0;
        vertex_a_y = '0;
        vertex_b_x = '0;
        vertex_b_y = '0;
        vertex_c_x = '0;
        vertex_c_y = '0;
        lo_deg = 16'd0;
        hi_deg = 16'd46080;
        snd_idle = 0;
        rcv_idle = 0;
        rcv_hold = 0;
        n_errors = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_windows();
        test_idling();
        test_backpressure();
        if (n_errors == 0 && angles_due.size() == 0)
            $display("** triangle_angle_range_check: PASSED **");
        else
            $display("** triangle_angle_range_check: FAILED **");
        $finish;
    end

endmodule
